// ===== rtl/core/vector_display_command_unit_defines.svh =====
// Assertion macros shared by the vector display command unit RTL.
`ifndef VECTOR_DISPLAY_COMMAND_UNIT_DEFINES_SVH
`define VECTOR_DISPLAY_COMMAND_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low
`define VDCU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vdcu check failed");

// Next-cycle implication, sampled on clk, quiet while arst_n is low
`define VDCU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vdcu check failed");

`endif

// ===== rtl/core/vdcu_pkg.sv =====
// Types, opcodes and word-count table for the vector display command unit.
`timescale 1ns / 1ps
`default_nettype none
package vdcu_pkg;

	// Opcodes of the first word
	localparam logic [31:0] OP_CLEAR    = 32'd0;
	localparam logic [31:0] OP_SET_POS  = 32'd1;
	localparam logic [31:0] OP_MOVE_POS = 32'd2;
	localparam logic [31:0] OP_SET_EXT  = 32'd3;
	localparam logic [31:0] OP_LINE     = 32'd4;
	localparam logic [31:0] OP_ARC      = 32'd5;
	localparam logic [31:0] OP_RECT     = 32'd6;
	localparam logic [31:0] OP_LINE_COL = 32'd7;
	localparam logic [31:0] OP_FILL_COL = 32'd8;
	localparam logic [31:0] OP_TEX_DRAW = 32'd9;
	localparam logic [31:0] OP_TEX_LOAD = 32'd10;
	localparam logic [31:0] OP_MAX      = OP_TEX_LOAD;

	// Primitive kinds
	localparam logic [2:0] KIND_CLEAR    = 3'd0;
	localparam logic [2:0] KIND_LINE     = 3'd1;
	localparam logic [2:0] KIND_ARC      = 3'd2;
	localparam logic [2:0] KIND_RECT     = 3'd3;
	localparam logic [2:0] KIND_TEX_DRAW = 3'd4;
	localparam logic [2:0] KIND_TEX_LOAD = 3'd5;

	// Buffer wraps after this many words
	localparam logic [1:0] BUF_WORDS = 2'd3;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] ext_x;
		logic signed [15:0] ext_y;
		logic [31:0]        rgba;
		logic               arc_vertical;
	} prim_t;

	// Words per command; zero for codes that never execute
	function automatic logic [1:0] op_words(input logic [31:0] op);
		logic [1:0] n;
		begin
			case (op)
				OP_CLEAR:    n = 2'd1;
				OP_SET_POS:  n = 2'd3;
				OP_MOVE_POS: n = 2'd3;
				OP_SET_EXT:  n = 2'd3;
				OP_LINE:     n = 2'd1;
				OP_ARC:      n = 2'd2;
				OP_RECT:     n = 2'd1;
				OP_LINE_COL: n = 2'd2;
				OP_FILL_COL: n = 2'd2;
				OP_TEX_DRAW: n = 2'd1;
				OP_TEX_LOAD: n = 2'd1;
				default:     n = 2'd0;
			endcase
			return n;
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/vdcu_cmd.sv =====
// Command buffer, pen, extent and colour state; decodes each word into a primitive.
`timescale 1ns / 1ps
`default_nettype none
module vdcu_cmd (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [31:0]   word,
	output logic               prim_valid,
	output vdcu_pkg::prim_t    prim
);
	import vdcu_pkg::*;

	logic [31:0]        opcode_q;
	logic [31:0]        arg_q;
	logic [1:0]         idx_q;
	logic signed [15:0] pen_x_q;
	logic signed [15:0] pen_y_q;
	logic signed [15:0] ext_x_q;
	logic signed [15:0] ext_y_q;
	logic [31:0]        line_rgba_q;
	logic [31:0]        fill_rgba_q;

	logic [1:0]         idx_cur;
	logic [1:0]         idx_new;
	logic [31:0]        opcode_nx;
	logic [31:0]        arg_nx;
	logic               done;
	logic signed [15:0] a_lo;
	logic signed [15:0] b_lo;
	logic signed [15:0] adv_x;
	logic signed [15:0] adv_y;

	// Place this word in the buffer, wrapping after three words
	always_comb begin
		idx_cur   = (idx_q == BUF_WORDS) ? 2'd0 : idx_q;
		idx_new   = idx_cur + 2'd1;
		opcode_nx = (idx_cur == 2'd0) ? word : opcode_q;
		arg_nx    = (idx_cur == 2'd1) ? word : arg_q;
		done      = (opcode_nx <= OP_MAX) && (op_words(opcode_nx) == idx_new);
		a_lo      = arg_nx[15:0];
		b_lo      = word[15:0];
		adv_x     = pen_x_q + ext_x_q;
		adv_y     = pen_y_q + ext_y_q;
	end

	// Form the primitive of a completed drawing command
	always_comb begin
		prim_valid = 1'b0;
		prim       = '0;
		if (done) begin
			case (opcode_nx)
				OP_CLEAR: begin
					prim_valid = 1'b1;
					prim.kind  = KIND_CLEAR;
				end
				OP_LINE, OP_ARC, OP_RECT, OP_TEX_DRAW: begin
					prim_valid  = 1'b1;
					prim.pos_x  = pen_x_q;
					prim.pos_y  = pen_y_q;
					prim.ext_x  = ext_x_q;
					prim.ext_y  = ext_y_q;
					case (opcode_nx)
						OP_LINE: begin
							prim.kind = KIND_LINE;
							prim.rgba = line_rgba_q;
						end
						OP_ARC: begin
							prim.kind         = KIND_ARC;
							prim.rgba         = line_rgba_q;
							prim.arc_vertical = (arg_nx != 32'd0);
						end
						OP_RECT: begin
							prim.kind = KIND_RECT;
							prim.rgba = fill_rgba_q;
						end
						default: begin
							prim.kind = KIND_TEX_DRAW;
						end
					endcase
				end
				OP_TEX_LOAD: begin
					prim_valid = 1'b1;
					prim.kind  = KIND_TEX_LOAD;
					prim.ext_x = ext_x_q;
					prim.ext_y = ext_y_q;
				end
				default: begin
					prim_valid = 1'b0;
				end
			endcase
		end
	end

	// Hold state; advance buffer and execute on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opcode_q    <= '0;
			arg_q       <= '0;
			idx_q       <= '0;
			pen_x_q     <= '0;
			pen_y_q     <= '0;
			ext_x_q     <= '0;
			ext_y_q     <= '0;
			line_rgba_q <= '0;
			fill_rgba_q <= '0;
		end else if (step) begin
			opcode_q <= opcode_nx;
			arg_q    <= arg_nx;
			idx_q    <= done ? 2'd0 : idx_new;
			if (done) begin
				case (opcode_nx)
					OP_SET_POS: begin
						pen_x_q <= a_lo;
						pen_y_q <= b_lo;
					end
					OP_MOVE_POS: begin
						pen_x_q <= pen_x_q + a_lo;
						pen_y_q <= pen_y_q + b_lo;
					end
					OP_SET_EXT: begin
						ext_x_q <= a_lo;
						ext_y_q <= b_lo;
					end
					OP_LINE, OP_ARC, OP_RECT, OP_TEX_DRAW: begin
						pen_x_q <= adv_x;
						pen_y_q <= adv_y;
					end
					OP_LINE_COL: begin
						line_rgba_q <= arg_nx;
					end
					OP_FILL_COL: begin
						fill_rgba_q <= arg_nx;
					end
					default: begin
						pen_x_q <= pen_x_q;
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/vdcu_out_reg.sv =====
// Result register holding one primitive until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none
module vdcu_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire vdcu_pkg::prim_t  prim_in,
	input  wire logic             take,
	output logic                  valid_q,
	output vdcu_pkg::prim_t       prim_q
);
	import vdcu_pkg::*;

	// Hold valid until the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	// Capture payload on load
	always_ff @(posedge clk) begin
		if (load) begin
			prim_q <= prim_in;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/vector_display_command_unit.sv =====
// Path: a word accepted into the input register is decoded into the result register that drives out_valid.
// Throughput: one word per cycle, unless a primitive must wait on a stalled result register.
// A stalled result register holds the input register only when it carries a primitive.
// Reset (arst_n low, asynchronous): buffer, pen, extent and colours clear to zero,
// and both valid flags drop.
`timescale 1ns / 1ps
`default_nettype none
`include "vector_display_command_unit_defines.svh"
module vector_display_command_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [31:0]        word,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              kind,
	output logic signed [15:0]      pos_x,
	output logic signed [15:0]      pos_y,
	output logic signed [15:0]      ext_x,
	output logic signed [15:0]      ext_y,
	output logic [31:0]             rgba,
	output logic                    arc_vertical
);
	import vdcu_pkg::*;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic        prim_valid;
	prim_t       prim;
	prim_t       prim_q;
	logic        out_free;
	logic        adv_s1;
	logic        load_out;

	// Advance stage 1 unless its primitive has nowhere to go
	assign out_free = !out_valid || out_ready;
	assign adv_s1   = valid_s1 && (!prim_valid || out_free);
	assign load_out = adv_s1 && prim_valid;
	assign in_ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= word;
		end
	end

	vdcu_cmd u_cmd (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv_s1),
		.word       (word_s1),
		.prim_valid (prim_valid),
		.prim       (prim)
	);

	vdcu_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load_out),
		.prim_in (prim),
		.take    (out_ready),
		.valid_q (out_valid),
		.prim_q  (prim_q)
	);

	assign kind         = prim_q.kind;
	assign pos_x        = prim_q.pos_x;
	assign pos_y        = prim_q.pos_y;
	assign ext_x        = prim_q.ext_x;
	assign ext_y        = prim_q.ext_y;
	assign rgba         = prim_q.rgba;
	assign arc_vertical = prim_q.arc_vertical;

	// An empty input stage always takes a word
	`VDCU_ASSERT_IMP(a_empty_ready, !valid_s1, in_ready)
	// Never overwrite a primitive still waiting at the output
	`VDCU_ASSERT_IMP(a_no_overwrite, out_valid && !out_ready, !load_out)
	// A loaded primitive shows up on the next cycle
	`VDCU_ASSERT_NXT(a_load_shows, load_out, out_valid)

endmodule
`default_nettype wire
